### sv/windowed_line_pattern_counter_defines.svh
// Assertion macros for the windowed line pattern counter.
`ifndef WINDOWED_LINE_PATTERN_COUNTER_DEFINES_SVH
`define WINDOWED_LINE_PATTERN_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WLPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wlpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WLPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wlpc assertion failed");

`endif

### sv/wlpc_pkg.sv
// Shared types and constants of the windowed line pattern counter.
package wlpc_pkg;

  localparam int unsigned TEXT_W      = 8;
  localparam int unsigned PAT_REG_W   = 64;
  localparam int unsigned PAT_LEN_W   = 5;
  localparam int unsigned WINDOW_W    = 9;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [TEXT_W-1:0]   NEWLINE_BYTE = 8'd10;
  localparam logic [TEXT_W-1:0]   ZERO_BYTE    = 8'd0;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd30;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_FIRST = 3'd0,
    REG_PATTERN_LAST  = 3'd1,
    REG_PATTERN_LEN   = 3'd2,
    REG_WINDOW        = 3'd3,
    REG_WARN_LEVEL    = 3'd4,
    REG_CRIT_LEVEL    = 3'd5
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_WARNING  = 2'd1,
    STATUS_CRITICAL = 2'd2,
    STATUS_UNKNOWN  = 2'd3
  } status_e;

  typedef struct packed {
    logic take;
    logic clear;
  } cell_ctrl_t;

endpackage

### sv/wlpc_cell.sv
// One cell of the prefix match chain: tracks a pattern prefix ending at the last byte.
module wlpc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wlpc_pkg::cell_ctrl_t          ctrl_i,
  input  logic [wlpc_pkg::TEXT_W-1:0]   text_byte_i,
  input  logic [wlpc_pkg::TEXT_W-1:0]   pat_byte_i,
  input  logic                          prev_flag_i,
  input  logic                          last_i,
  output logic                          flag_o,
  output logic                          hit_o
);

  logic flag_q, flag_d;
  logic step;

  assign step = prev_flag_i && (text_byte_i == pat_byte_i);

  always_comb begin
    flag_d = flag_q;
    if (ctrl_i.clear) begin
      flag_d = 1'b0;
    end else if (ctrl_i.take) begin
      flag_d = step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign flag_o = flag_q;
  assign hit_o  = ctrl_i.take && step && last_i;

endmodule

### sv/wlpc_ring.sv
// Ring memory of running match totals, one entry per closed line.
module wlpc_ring #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 9
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] ring_mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ring_mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= ring_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/windowed_line_pattern_counter.sv
// Top level of the windowed line pattern counter.
//
// Text bytes arrive on the s_axis channel, one per transfer; a transfer with
// tlast high closes the text and its tdata is ignored. Byte 10 ends a line.
// A chain of cells, one per pattern byte, tracks partial pattern matches, so
// every byte is taken as it arrives and bytes may arrive back to back.
// Each closed line writes the running match total into a ring memory; at the
// end of the text the window count is that total minus, if the text has more
// lines than the window, the ring entry of the line just before the window.
// One result leaves on m_axis after the closing transfer has passed the
// registered ring read and then the output register. Throughput is one
// transfer per cycle while the receiver does not stall.
// When the receiver stalls, one finished result waits in the output register
// and one more in the read stage; s_axis_tready_o then drops until the
// output register frees up.
// Configuration writes on the cfg channel are always taken. Reset clears
// the line state, the ring position and the registers to their reset values;
// the ring memory itself is not cleared and only entries of the current
// text are read.
module windowed_line_pattern_counter #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned LINES_MAX   = 256,
  parameter int unsigned LINE_BYTES  = 299
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wlpc_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [wlpc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [wlpc_pkg::TEXT_W-1:0]           s_axis_tdata_i,  // [7:0] text_byte
  input  logic                                  s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [8:0] match_count, [10:9] status_code, [15:11] zero
  output logic [wlpc_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o
);

  localparam int unsigned AW   = (LINES_MAX > 1) ? $clog2(LINES_MAX) : 1;
  localparam int unsigned CW   = $clog2(LINES_MAX + 1);
  localparam int unsigned HW   = $clog2(LINES_MAX + 2);
  localparam int unsigned LBW  = $clog2(LINE_BYTES + 1);
  localparam int unsigned CMPW = (CW > wlpc_pkg::LEVEL_W) ? CW : wlpc_pkg::LEVEL_W;
  localparam int unsigned PADW = wlpc_pkg::OUT_DATA_W - wlpc_pkg::COUNT_W - wlpc_pkg::STATUS_W;

  logic [wlpc_pkg::PAT_REG_W-1:0]  pat_first_q, pat_last_q;
  logic [wlpc_pkg::PAT_LEN_W-1:0]  pat_len_q;
  logic [wlpc_pkg::WINDOW_W-1:0]   window_q;
  logic [wlpc_pkg::LEVEL_W-1:0]    warn_q, crit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_first_q <= '0;
      pat_last_q  <= '0;
      pat_len_q   <= '0;
      window_q    <= wlpc_pkg::WINDOW_RESET;
      warn_q      <= '0;
      crit_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (wlpc_pkg::cfg_reg_e'(cfg_index_i))
        wlpc_pkg::REG_PATTERN_FIRST: pat_first_q <= cfg_data_i;
        wlpc_pkg::REG_PATTERN_LAST:  pat_last_q  <= cfg_data_i;
        wlpc_pkg::REG_PATTERN_LEN:   pat_len_q   <= cfg_data_i[wlpc_pkg::PAT_LEN_W-1:0];
        wlpc_pkg::REG_WINDOW:        window_q    <= cfg_data_i[wlpc_pkg::WINDOW_W-1:0];
        wlpc_pkg::REG_WARN_LEVEL:    warn_q      <= cfg_data_i[wlpc_pkg::LEVEL_W-1:0];
        wlpc_pkg::REG_CRIT_LEVEL:    crit_q      <= cfg_data_i[wlpc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [wlpc_pkg::PAT_LEN_W-1:0] len_eff;
  logic [CMPW-1:0]                win_ext;
  logic [CW-1:0]                  win_eff;

  always_comb begin
    len_eff = pat_len_q;
    if (pat_len_q > wlpc_pkg::PAT_LEN_W'(PATTERN_MAX)) begin
      len_eff = wlpc_pkg::PAT_LEN_W'(PATTERN_MAX);
    end
    win_ext = CMPW'(window_q);
    if (win_ext == '0) begin
      win_ext = CMPW'(1);
    end else if (win_ext > CMPW'(LINES_MAX)) begin
      win_ext = CMPW'(LINES_MAX);
    end
    win_eff = win_ext[CW-1:0];
  end

  logic s1_valid_q, s1_valid_d;
  logic s1_move;
  logic out_valid_q, out_valid_d;

  assign s1_move         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || s1_move;

  logic in_fire, byte_fire, end_fire, is_nl, close_line, byte_open, take, zero_set;
  logic [LBW-1:0] bytes_q, bytes_d;
  logic           zero_seen_q, zero_seen_d;
  logic           matched_q, matched_d;

  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign byte_fire  = in_fire && !s_axis_tlast_i;
  assign end_fire   = in_fire && s_axis_tlast_i;
  assign is_nl      = s_axis_tdata_i == wlpc_pkg::NEWLINE_BYTE;
  assign close_line = (byte_fire && is_nl) || end_fire;
  assign byte_open  = byte_fire && !is_nl && !zero_seen_q && (bytes_q < LBW'(LINE_BYTES));
  assign take       = byte_open && (s_axis_tdata_i != wlpc_pkg::ZERO_BYTE);
  assign zero_set   = byte_open && (s_axis_tdata_i == wlpc_pkg::ZERO_BYTE);

  wlpc_pkg::cell_ctrl_t        cell_ctrl;
  logic [PATTERN_MAX-1:0]      cell_flag, cell_hit;
  logic                        hit_any;

  assign cell_ctrl.take  = take;
  assign cell_ctrl.clear = close_line;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [wlpc_pkg::TEXT_W-1:0] pat_byte;
    logic                        prev_flag;
    if (j < 8) begin : g_first
      assign pat_byte = pat_first_q[j*wlpc_pkg::TEXT_W +: wlpc_pkg::TEXT_W];
    end else begin : g_last
      assign pat_byte = pat_last_q[(j-8)*wlpc_pkg::TEXT_W +: wlpc_pkg::TEXT_W];
    end
    if (j == 0) begin : g_head
      assign prev_flag = 1'b1;
    end else begin : g_link
      assign prev_flag = cell_flag[j-1];
    end
    wlpc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .text_byte_i (s_axis_tdata_i),
      .pat_byte_i  (pat_byte),
      .prev_flag_i (prev_flag),
      .last_i      (len_eff == wlpc_pkg::PAT_LEN_W'(j + 1)),
      .flag_o      (cell_flag[j]),
      .hit_o       (cell_hit[j])
    );
  end

  assign hit_any = |cell_hit;

  always_comb begin
    bytes_d     = bytes_q;
    zero_seen_d = zero_seen_q;
    matched_d   = matched_q;
    if (close_line) begin
      bytes_d     = '0;
      zero_seen_d = 1'b0;
      matched_d   = 1'b0;
    end else begin
      if (take) begin
        bytes_d = bytes_q + LBW'(1);
      end
      if (zero_set) begin
        zero_seen_d = 1'b1;
      end
      if (hit_any) begin
        matched_d = 1'b1;
      end
    end
  end

  logic [AW-1:0] pos_q, pos_d;
  logic [HW-1:0] held_q, held_d, held_after;
  logic [CW-1:0] cum_q, cum_d, cum_next;
  logic          line_hit;
  logic [CMPW:0] rd_addr_ext;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_data;

  assign line_hit   = matched_q || (len_eff == '0);
  assign cum_next   = cum_q + CW'(line_hit);
  assign held_after = (held_q == HW'(LINES_MAX + 1)) ? held_q : held_q + HW'(1);

  always_comb begin
    if ((CMPW + 1)'(pos_q) >= (CMPW + 1)'(win_eff)) begin
      rd_addr_ext = (CMPW + 1)'(pos_q) - (CMPW + 1)'(win_eff);
    end else begin
      rd_addr_ext = (CMPW + 1)'(pos_q) + (CMPW + 1)'(LINES_MAX) - (CMPW + 1)'(win_eff);
    end
    rd_addr = rd_addr_ext[AW-1:0];
  end

  always_comb begin
    pos_d  = pos_q;
    held_d = held_q;
    cum_d  = cum_q;
    if (end_fire) begin
      pos_d  = '0;
      held_d = '0;
      cum_d  = '0;
    end else if (close_line) begin
      pos_d  = (pos_q == AW'(LINES_MAX - 1)) ? '0 : pos_q + AW'(1);
      held_d = held_after;
      cum_d  = cum_next;
    end
  end

  wlpc_ring #(
    .DEPTH (LINES_MAX),
    .AW    (AW),
    .DW    (CW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (close_line),
    .wr_addr_i (pos_q),
    .wr_data_i (cum_next),
    .rd_en_i   (end_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  logic [CW-1:0] s1_cum_q;
  logic          s1_use_q;

  assign s1_valid_d = end_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q     <= '0;
      zero_seen_q <= 1'b0;
      matched_q   <= 1'b0;
      pos_q       <= '0;
      held_q      <= '0;
      cum_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bytes_q     <= bytes_d;
      zero_seen_q <= zero_seen_d;
      matched_q   <= matched_d;
      pos_q       <= pos_d;
      held_q      <= held_d;
      cum_q       <= cum_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      s1_cum_q <= cum_next;
      s1_use_q <= CMPW'(held_after) > win_ext;
    end
  end

  logic [CW-1:0]                  win_count;
  logic [CMPW-1:0]                count_ext;
  wlpc_pkg::status_e              status;
  logic [wlpc_pkg::COUNT_W-1:0]   out_count_q;
  wlpc_pkg::status_e              out_status_q;

  assign win_count = s1_cum_q - (s1_use_q ? rd_data : '0);
  assign count_ext = CMPW'(win_count);

  always_comb begin
    if (crit_q < warn_q) begin
      status = wlpc_pkg::STATUS_UNKNOWN;
    end else if (count_ext >= CMPW'(crit_q)) begin
      status = wlpc_pkg::STATUS_CRITICAL;
    end else if (count_ext >= CMPW'(warn_q)) begin
      status = wlpc_pkg::STATUS_WARNING;
    end else begin
      status = wlpc_pkg::STATUS_OK;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_move) begin
      out_count_q  <= count_ext[wlpc_pkg::COUNT_W-1:0];
      out_status_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {PADW'(0), out_status_q, out_count_q};

  `include "windowed_line_pattern_counter_defines.svh"

  `WLPC_ASSERT_IMP(a_stall_blocks_input, s1_valid_q && !s1_move, !s_axis_tready_o)
  `WLPC_ASSERT_NXT(a_end_loads_stage, end_fire, s1_valid_q)
  `WLPC_ASSERT_NXT(a_end_rewinds, end_fire, pos_q == '0 && held_q == '0 && cum_q == '0)
  `WLPC_ASSERT_IMP(a_no_take_after_zero, zero_seen_q, !take)

endmodule

### bench/windowed_line_pattern_counter_checker.sv
// Checker that predicts and compares the window counts of the line pattern counter.
`timescale 1ns / 1ps

module windowed_line_pattern_counter_checker
  import wlpc_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned LINES_MAX   = 256,
  parameter int unsigned LINE_BYTES  = 299
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [TEXT_W-1:0]      s_axis_tdata_i,  // [7:0] text_byte
  input  logic                   s_axis_tlast_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  // [8:0] match_count, [10:9] status_code, [15:11] zero
  input  logic [OUT_DATA_W-1:0]  m_axis_tdata_i,
  output int unsigned            fail_count_o,
  output int unsigned            results_pending_o
);

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    status_e            status;
  } window_result_t;

  logic [PAT_REG_W-1:0] pat_first;
  logic [PAT_REG_W-1:0] pat_last;
  logic [PAT_LEN_W-1:0] pat_len;
  logic [WINDOW_W-1:0]  window_len;
  logic [LEVEL_W-1:0]   warn_level;
  logic [LEVEL_W-1:0]   crit_level;

  logic [TEXT_W-1:0] recent_bytes [PATTERN_MAX];
  bit                line_hit;
  int unsigned       line_len;
  bit                zero_seen;
  bit                line_hits_ring [LINES_MAX];
  int unsigned       ring_pos;
  int unsigned       lines_held;

  window_result_t window_results_q [$];
  int unsigned    mismatches;
  int unsigned    pending_n;

  assign fail_count_o      = mismatches;
  assign results_pending_o = pending_n;

  function automatic int unsigned active_pattern_len();
    return (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
  endfunction

  function automatic logic [TEXT_W-1:0] pattern_byte(input int unsigned i);
    logic [2*PAT_REG_W-1:0] both;
    both = {pat_last, pat_first};
    return both[8*i +: 8];
  endfunction

  function automatic void clear_line();
    for (int k = 0; k < PATTERN_MAX; k++) recent_bytes[k] = ZERO_BYTE;
    line_hit  = 1'b0;
    line_len  = 0;
    zero_seen = 1'b0;
  endfunction

  function automatic void close_line();
    line_hits_ring[ring_pos] = line_hit || (active_pattern_len() == 0);
    ring_pos = (ring_pos + 1) % LINES_MAX;
    if (lines_held < LINES_MAX) lines_held++;
    clear_line();
  endfunction

  function automatic void take_text_byte(input logic [TEXT_W-1:0] b);
    int unsigned len;
    bit          same;
    if (zero_seen || line_len >= LINE_BYTES) return;
    if (b == ZERO_BYTE) begin
      zero_seen = 1'b1;
      return;
    end
    line_len++;
    len = active_pattern_len();
    if (len != 0 && line_len >= len && pattern_byte(len - 1) == b) begin
      same = 1'b1;
      for (int unsigned k = 1; k < len; k++) begin
        if (recent_bytes[k-1] != pattern_byte(len - 1 - k)) same = 1'b0;
      end
      if (same) line_hit = 1'b1;
    end
    for (int k = PATTERN_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = b;
  endfunction

  function automatic window_result_t close_text();
    window_result_t res;
    int unsigned    win;
    int unsigned    n;
    int unsigned    pos;
    int unsigned    total;
    close_line();
    win = window_len;
    if (win == 0) win = 1;
    if (win > LINES_MAX) win = LINES_MAX;
    n = (lines_held < win) ? lines_held : win;
    total = 0;
    pos = ring_pos;
    for (int unsigned k = 0; k < n; k++) begin
      pos = (pos + LINES_MAX - 1) % LINES_MAX;
      total += line_hits_ring[pos];
    end
    res.count = total[COUNT_W-1:0];
    if (crit_level < warn_level) res.status = STATUS_UNKNOWN;
    else if (total >= crit_level) res.status = STATUS_CRITICAL;
    else if (total >= warn_level) res.status = STATUS_WARNING;
    else res.status = STATUS_OK;
    ring_pos   = 0;
    lines_held = 0;
    clear_line();
    return res;
  endfunction

  function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (cfg_reg_e'(idx))
      REG_PATTERN_FIRST: pat_first  = val;
      REG_PATTERN_LAST:  pat_last   = val;
      REG_PATTERN_LEN:   pat_len    = val[PAT_LEN_W-1:0];
      REG_WINDOW:        window_len = val[WINDOW_W-1:0];
      REG_WARN_LEVEL:    warn_level = val[LEVEL_W-1:0];
      REG_CRIT_LEVEL:    crit_level = val[LEVEL_W-1:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t want;
    if (!rst_ni) begin
      pat_first  = '0;
      pat_last   = '0;
      pat_len    = '0;
      window_len = WINDOW_RESET;
      warn_level = '0;
      crit_level = '0;
      clear_line();
      for (int k = 0; k < LINES_MAX; k++) line_hits_ring[k] = 1'b0;
      ring_pos   = 0;
      lines_held = 0;
      window_results_q.delete();
      mismatches = 0;
      pending_n  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_cfg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tlast_i) window_results_q.push_back(close_text());
        else if (s_axis_tdata_i == NEWLINE_BYTE) close_line();
        else take_text_byte(s_axis_tdata_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (window_results_q.size() == 0) begin
          $error("unexpected result transfer: match_count actual %0d, status_code actual %0d",
                 m_axis_tdata_i[8:0], m_axis_tdata_i[10:9]);
          mismatches++;
        end else begin
          want = window_results_q.pop_front();
          if (m_axis_tdata_i[8:0] !== want.count) begin
            $error("match_count mismatch: expected %0d, actual %0d",
                   want.count, m_axis_tdata_i[8:0]);
            mismatches++;
          end
          if (m_axis_tdata_i[10:9] !== want.status) begin
            $error("status_code mismatch: expected %0d, actual %0d",
                   want.status, m_axis_tdata_i[10:9]);
            mismatches++;
          end
          if (m_axis_tdata_i[15:11] !== 5'd0) begin
            $error("padding mismatch: expected %0d, actual %0d",
                   5'd0, m_axis_tdata_i[15:11]);
            mismatches++;
          end
        end
      end
      pending_n = window_results_q.size();
    end
  end

endmodule

### bench/windowed_line_pattern_counter_tb.sv
// Testbench top that drives text and configuration into the line pattern counter.
`timescale 1ns / 1ps

module windowed_line_pattern_counter_tb
  import wlpc_pkg::*;
;

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned MIN_TEXTS    = 8;
  localparam int unsigned STALL_LIMIT  = 4000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_FIRST;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TEXT_W-1:0]      s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [OUT_DATA_W-1:0]  m_tdata;

  int unsigned fail_count;
  int unsigned results_pending;

  int unsigned send_idle_pct = 0;
  int unsigned idle_now = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned quiet_cycles = 0;

  logic [2*PAT_REG_W-1:0] pat_bytes = '0;
  int unsigned            pat_used = 0;
  logic [TEXT_W-1:0]      text_bytes_q [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  windowed_line_pattern_counter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  windowed_line_pattern_counter_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .s_axis_tvalid_i   (s_tvalid),
    .s_axis_tready_i   (s_tready),
    .s_axis_tdata_i    (s_tdata),
    .s_axis_tlast_i    (s_tlast),
    .m_axis_tvalid_i   (m_tvalid),
    .m_axis_tready_i   (m_tready),
    .m_axis_tdata_i    (m_tdata),
    .fail_count_o      (fail_count),
    .results_pending_o (results_pending)
  );

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input logic [TEXT_W-1:0] b, input logic last);
    if (idle_now != 0 && $urandom_range(99, 0) < idle_now) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < idle_now);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(negedge clk_i);
    while (!s_tready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (results_pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [PAT_REG_W-1:0] first, input logic [PAT_REG_W-1:0] last,
                           input logic [PAT_LEN_W-1:0] len, input logic [WINDOW_W-1:0] win,
                           input logic [LEVEL_W-1:0] warn, input logic [LEVEL_W-1:0] crit);
    pat_bytes = {last, first};
    pat_used  = (len > 16) ? 16 : len;
    write_reg(REG_PATTERN_FIRST, first);
    write_reg(REG_PATTERN_LAST, last);
    write_reg(REG_PATTERN_LEN, CFG_DATA_W'(len));
    write_reg(REG_WINDOW, CFG_DATA_W'(win));
    write_reg(REG_WARN_LEVEL, CFG_DATA_W'(warn));
    write_reg(REG_CRIT_LEVEL, CFG_DATA_W'(crit));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TEXT_W-1:0] alphabet_byte();
    return ($urandom_range(9, 0) < 8) ? TEXT_W'(8'h61 + $urandom_range(2, 0))
                                      : TEXT_W'($urandom_range(255, 0));
  endfunction

  function automatic logic [TEXT_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50 && pat_used != 0) return pat_bytes[8*$urandom_range(pat_used - 1, 0) +: 8];
    if (r < 85) return TEXT_W'(8'h61 + $urandom_range(2, 0));
    if (r < 99) return TEXT_W'($urandom_range(255, 1));
    return ZERO_BYTE;
  endfunction

  function automatic logic [TEXT_W-1:0] filler_byte();
    logic [TEXT_W-1:0] b;
    b = pick_byte();
    if (b == ZERO_BYTE || b == NEWLINE_BYTE) b = 8'h63;
    return b;
  endfunction

  task automatic push_pattern();
    int unsigned m;
    if (pat_used == 0) begin
      text_bytes_q.push_back(8'h61);
    end else begin
      m = ($urandom_range(9, 0) < 7) ? pat_used : $urandom_range(pat_used, 1);
      for (int unsigned i = 0; i < m; i++) text_bytes_q.push_back(pat_bytes[8*i +: 8]);
    end
  endtask

  task automatic build_line(input bit many_lines, input bit long_ok);
    int unsigned kind;
    int unsigned frag;
    kind = $urandom_range(99, 0);
    if (many_lines) begin
      if (kind >= 50) repeat ($urandom_range(3, 1)) text_bytes_q.push_back(pick_byte());
    end else if (kind < 12) begin
      return;
    end else if (long_ok && kind < 45) begin
      repeat ($urandom_range(310, 270)) text_bytes_q.push_back(filler_byte());
      push_pattern();
      repeat ($urandom_range(3, 0)) text_bytes_q.push_back(filler_byte());
    end else begin
      repeat ($urandom_range(4, 1)) begin
        frag = $urandom_range(9, 0);
        if (frag < 4) push_pattern();
        else if (frag < 8) repeat ($urandom_range(5, 1)) text_bytes_q.push_back(pick_byte());
        else if (frag == 8) text_bytes_q.push_back(ZERO_BYTE);
        else text_bytes_q.push_back(TEXT_W'($urandom_range(255, 0)));
      end
    end
  endtask

  task automatic flush_text();
    foreach (text_bytes_q[j]) send_item(text_bytes_q[j], 1'b0);
    send_item(TEXT_W'($urandom_range(255, 0)), 1'b1);
    text_bytes_q.delete();
    texts_sent++;
  endtask

  task automatic send_text(input bit many_lines, input bit long_ok);
    int unsigned n_lines;
    idle_now = ($urandom_range(4, 0) == 0) ? 0 : send_idle_pct;
    n_lines = many_lines ? $urandom_range(300, 257) : $urandom_range(6, 1);
    for (int unsigned i = 0; i < n_lines; i++) begin
      build_line(many_lines, long_ok);
      if (i + 1 < n_lines) text_bytes_q.push_back(NEWLINE_BYTE);
    end
    flush_text();
  endtask

  task automatic random_cfg(input bit wide_window);
    logic [PAT_REG_W-1:0] first;
    logic [PAT_REG_W-1:0] last;
    logic [PAT_LEN_W-1:0] len;
    logic [WINDOW_W-1:0]  win;
    logic [LEVEL_W-1:0]   warn;
    logic [LEVEL_W-1:0]   crit;
    int unsigned          r;
    if ($urandom_range(9, 0) == 0) begin
      first = {$urandom, $urandom};
      last  = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < 8; i++) begin
        first[8*i +: 8] = alphabet_byte();
        last[8*i +: 8]  = alphabet_byte();
      end
    end
    r = $urandom_range(99, 0);
    if (r < 10) len = '0;
    else if (r < 20) len = PAT_LEN_W'(16);
    else if (r < 26) len = PAT_LEN_W'($urandom_range(31, 17));
    else if (r < 80) len = PAT_LEN_W'($urandom_range(4, 1));
    else len = PAT_LEN_W'($urandom_range(15, 5));
    r = $urandom_range(99, 0);
    if (wide_window) win = (r < 50) ? 9'd256 : WINDOW_W'($urandom_range(511, 257));
    else if (r < 10) win = '0;
    else if (r < 20) win = WINDOW_W'(1);
    else if (r < 30) win = WINDOW_W'(256);
    else if (r < 35) win = WINDOW_W'($urandom_range(511, 257));
    else if (r < 45) win = WINDOW_W'($urandom_range(511, 0));
    else win = WINDOW_W'($urandom_range(40, 1));
    r = $urandom_range(99, 0);
    if (r < 10) begin
      warn = '0;
      crit = '0;
    end else if (r < 20) begin
      warn = 16'hffff;
      crit = 16'hffff;
    end else if (r < 30) begin
      warn = LEVEL_W'($urandom_range(20, 1));
      crit = LEVEL_W'($urandom_range(warn - 1, 0));
    end else if (r < 40) begin
      warn = LEVEL_W'($urandom);
      crit = LEVEL_W'($urandom);
    end else begin
      warn = LEVEL_W'($urandom_range(8, 0));
      crit = LEVEL_W'(warn + $urandom_range(8, 0));
    end
    write_cfg(first, last, len, win, warn, crit);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase;
    bit          first_text;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty text under the reset settings: one empty line, which always matches.
    flush_text();

    // A zero byte hides a later pattern; the last line has no newline.
    wait_idle();
    write_cfg(64'h6261, 64'h0, 5'd2, 9'd2, 16'd1, 16'd2);
    text_bytes_q = '{8'h61, 8'h62, NEWLINE_BYTE, ZERO_BYTE, 8'h61, 8'h62,
                     NEWLINE_BYTE, 8'hff, 8'h61, 8'h62};
    flush_text();

    // Oversized pattern length, window of zero and inverted thresholds.
    wait_idle();
    write_cfg({8{8'h61}}, {8{8'h61}}, 5'd31, 9'd0, 16'd5, 16'd4);
    text_bytes_q = '{NEWLINE_BYTE};
    flush_text();

    // A pattern holding a newline never matches; window above the maximum.
    wait_idle();
    write_cfg(64'h0a, 64'h0, 5'd1, 9'd511, 16'd0, 16'hffff);
    text_bytes_q = '{8'h61};
    flush_text();

    random_start = items_sent;
    first_text = 1'b1;
    while (items_sent - random_start < RANDOM_ITEMS || texts_sent < MIN_TEXTS) begin
      phase = (items_sent - random_start) * 4 / RANDOM_ITEMS;
      if (phase > 3) phase = 3;
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
      endcase
      if (first_text || $urandom_range(3, 0) == 0) begin
        wait_idle();
        random_cfg(first_text);
      end else if ($urandom_range(7, 0) == 0) begin
        wait_idle();
      end
      send_text(first_text || $urandom_range(49, 0) == 0, $urandom_range(9, 0) == 0);
      first_text = 1'b0;
    end

    wait_idle();
    if (fail_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
